// ===== src/chma_pkg.sv =====
// ----------------------------------------------------------------------------
// chma_pkg: shared types and constants
// Constants, arctangent table and controller interface types for the
// compass heading moving average unit.
// ----------------------------------------------------------------------------
package chma_pkg;

	localparam int CORDIC_STEPS = 18;
	localparam int STEP_W       = 5;
	localparam int CW           = 20;
	localparam int ZW           = 24;
	localparam int HEAD_W       = 17;
	localparam int HRAW_W       = 19;
	localparam int OUT_W        = 9;

	localparam logic signed [HRAW_W-1:0] HEAD_90_Q8  = 19'sd23040;
	localparam logic signed [HRAW_W-1:0] HEAD_270_Q8 = 19'sd69120;
	localparam logic signed [HRAW_W-1:0] HEAD_MAX_Q8 = 19'sd92159;
	localparam logic [HEAD_W-1:0]        HEAD_180_Q8 = 17'd46080;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT,
		ST_HEAD,
		ST_ACC,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic rot;
		logic head;
		logic acc;
		logic div;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic rot_last;
	} status_t;

	// Arctangent of 2^-i in units of 2^-16 degree.
	function automatic logic [21:0] atan_lut(input logic [STEP_W-1:0] idx);
		logic [21:0] v;
		unique case (idx)
			5'd0:    v = 22'd2949120;
			5'd1:    v = 22'd1740967;
			5'd2:    v = 22'd919879;
			5'd3:    v = 22'd466945;
			5'd4:    v = 22'd234379;
			5'd5:    v = 22'd117304;
			5'd6:    v = 22'd58666;
			5'd7:    v = 22'd29335;
			5'd8:    v = 22'd14668;
			5'd9:    v = 22'd7334;
			5'd10:   v = 22'd3667;
			5'd11:   v = 22'd1833;
			5'd12:   v = 22'd917;
			5'd13:   v = 22'd458;
			5'd14:   v = 22'd229;
			5'd15:   v = 22'd115;
			5'd16:   v = 22'd57;
			5'd17:   v = 22'd29;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/compass_heading_moving_average_unit.sv =====
// ----------------------------------------------------------------------------
// compass_heading_moving_average_unit: compass heading with moving average
// Converts magnetometer X/Y pairs to headings and averages the last
// AVG_DEPTH of them.
// ----------------------------------------------------------------------------
// Each accepted beat carries one X/Y sample pair and yields one output beat
// holding the mean of the last AVG_DEPTH headings in whole degrees. The mean
// is plain arithmetic with no wrap handling at north, and the history starts
// as zeros after reset. Each sample passes through the accepting step, the
// serial CORDIC arctangent, the heading, the ring update, the average and
// the output load, and a new sample is accepted only after the previous one
// has left the output load step. The result waits in the output register,
// so the next sample is taken while it is still pending; only the output
// load step stalls while an earlier result has not been taken.
// ----------------------------------------------------------------------------
module compass_heading_moving_average_unit
	import chma_pkg::*;
#(
	parameter int AVG_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] field_x, [31:16] field_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [8:0] heading_deg, [15:9] zero
);

	cmd_t             cmd;
	status_t          sts;
	logic [OUT_W-1:0] heading_deg;

	chma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	chma_dp #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.field_x     (s_tdata[15:0]),
		.field_y     (s_tdata[31:16]),
		.heading_deg (heading_deg)
	);

	assign m_tdata = {7'b0, heading_deg};

endmodule

// ===== src/chma_ctrl.sv =====
// ----------------------------------------------------------------------------
// chma_ctrl: sequencing controller
// Walks each sample through rotation, heading, accumulation, division and
// output load, and owns the input ready and the output valid flag.
// ----------------------------------------------------------------------------
module chma_ctrl
	import chma_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_ROT;
			ST_ROT:  if (sts.rot_last) state_nxt = ST_HEAD;
			ST_HEAD: state_nxt = ST_ACC;
			ST_ACC:  state_nxt = ST_DIV;
			ST_DIV:  state_nxt = ST_OUT;
			ST_OUT:  if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_ROT:  cmd.rot = 1'b1;
			ST_HEAD: cmd.head = 1'b1;
			ST_ACC:  cmd.acc = 1'b1;
			ST_DIV:  cmd.div = 1'b1;
			ST_OUT:  cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/chma_dp.sv =====
// ----------------------------------------------------------------------------
// chma_dp: heading and averaging datapath
// Serial CORDIC arctangent, heading formation, heading ring with running
// sum, and a reciprocal multiply that yields the average in whole degrees.
// ----------------------------------------------------------------------------
module chma_dp
	import chma_pkg::*;
#(
	parameter int AVG_DEPTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output status_t                 sts,
	input  logic signed [15:0]      field_x,
	input  logic signed [15:0]      field_y,
	output logic        [OUT_W-1:0] heading_deg
);

	localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int SUM_W  = HEAD_W + $clog2(AVG_DEPTH);
	localparam int QB     = SUM_W - 8;
	localparam int RSH    = QB + $clog2(AVG_DEPTH);
	localparam int MW     = QB + 1;
	localparam int PW     = QB + MW;
	localparam logic [MW-1:0]     RECIP     = MW'((2 ** RSH + AVG_DEPTH - 1) / AVG_DEPTH);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_DEPTH - 1);

	logic signed [CW-1:0]     cx_q, cy_q;
	logic signed [ZW-1:0]     z_q;
	logic [STEP_W-1:0]        step_q;
	logic                     y_zero_q, y_neg_q, x_neg_q;
	logic signed [CW-1:0]     ax, ay, sx, sy;
	logic signed [ZW-1:0]     lut_s;

	logic signed [ZW-1:0]     phi_sum;
	logic signed [15:0]       phi8;
	logic signed [HRAW_W-1:0] h_raw;
	logic [HEAD_W-1:0]        h_new;
	logic [HEAD_W-1:0]        head_q;

	logic [HEAD_W-1:0]        ring_mem [AVG_DEPTH];
	logic [HEAD_W-1:0]        ring_rd_q;
	logic [AVG_DEPTH-1:0]     ring_vld_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         old_val;
	logic [SUM_W-1:0]         sum_new;

	logic [PW-1:0]            quo_prod;
	logic [OUT_W-1:0]         quo_q;
	logic [OUT_W-1:0]         out_q;

	// CORDIC vectoring, one micro-rotation per cycle.
	assign ax    = CW'(field_x);
	assign ay    = CW'(field_y);
	assign sx    = cx_q >>> step_q;
	assign sy    = cy_q >>> step_q;
	assign lut_s = {2'b00, atan_lut(step_q)};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q     <= field_y[15] ? -ay : ay;
			cy_q     <= field_y[15] ? -ax : ax;
			z_q      <= '0;
			step_q   <= '0;
			y_zero_q <= (field_y == 16'sd0);
			y_neg_q  <= field_y[15];
			x_neg_q  <= field_x[15];
		end else if (cmd.rot) begin
			step_q <= step_q + STEP_W'(1);
			if (cy_q != '0) begin
				if (!cy_q[CW-1]) begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					z_q  <= z_q + lut_s;
				end else begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					z_q  <= z_q - lut_s;
				end
			end
		end
	end

	assign sts.rot_last = (step_q == STEP_W'(CORDIC_STEPS - 1));

	// Heading in Q9.8 from the rounded angle, clamped below 360 degrees.
	assign phi_sum = z_q + 24'sd128;
	assign phi8    = 16'(phi_sum >>> 8);
	assign h_raw   = (y_neg_q ? HEAD_270_Q8 : HEAD_90_Q8) - {{3{phi8[15]}}, phi8};

	always_comb begin
		if (y_zero_q) begin
			h_new = x_neg_q ? HEAD_180_Q8 : '0;
		end else if (h_raw < 0) begin
			h_new = '0;
		end else if (h_raw > HEAD_MAX_Q8) begin
			h_new = HEAD_MAX_Q8[HEAD_W-1:0];
		end else begin
			h_new = h_raw[HEAD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.head) begin
			head_q    <= h_new;
			ring_rd_q <= ring_mem[slot_q];
		end
		if (cmd.acc) begin
			ring_mem[slot_q] <= head_q;
		end
	end

	// Entries never written read as zero.
	assign old_val = ring_vld_q[slot_q] ? SUM_W'(ring_rd_q) : '0;
	assign sum_new = sum_q - old_val + SUM_W'(head_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			slot_q     <= '0;
			sum_q      <= '0;
		end else if (cmd.acc) begin
			ring_vld_q[slot_q] <= 1'b1;
			slot_q             <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
			sum_q              <= sum_new;
		end
	end

	// The sum in whole degrees times a scaled reciprocal of the ring depth
	// gives the exact truncated mean over the whole range of the sum.
	assign quo_prod = PW'(sum_q[SUM_W-1:8]) * PW'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			quo_q <= quo_prod[RSH +: OUT_W];
		end
		if (cmd.out_load) begin
			out_q <= quo_q;
		end
	end

	assign heading_deg = out_q;

endmodule
